@@ src/mbl_pkg.sv @@
package mbl_pkg;

  // Field widths
  localparam int unsigned CHAN_W   = 3;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COEF_W   = 18;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned PROD_W   = COEF_W + SAMPLE_W;
  localparam int unsigned ACC_W    = PROD_W + 4;
  localparam int unsigned Q_W      = ACC_W - FRAC_W;

  // Filter order, fixed: two past inputs and two past outputs per channel
  localparam int unsigned ORDER        = 2;
  localparam int unsigned CHANNELS_DEF = 8;

  // Register port
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [2:0] {
    REG_ENABLE = 3'd0,
    REG_NUM0   = 3'd1,
    REG_NUM1   = 3'd2,
    REG_NUM2   = 3'd3,
    REG_DEN1   = 3'd4,
    REG_DEN2   = 3'd5
  } reg_idx_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // One channel's history entry
  typedef struct packed {
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } hist_t;

  localparam int unsigned HIST_W = 2 * ORDER * SAMPLE_W;

  localparam acc_t ROUND_BIAS = ACC_W'(32'sd32768);

  // Q2.16 coefficient times integer sample
  function automatic prod_t mul(input coef_t c, input sample_t s);
    prod_t ce;
    prod_t se;
    ce = {{(PROD_W-COEF_W){c[COEF_W-1]}}, c};
    se = {{(PROD_W-SAMPLE_W){s[SAMPLE_W-1]}}, s};
    return ce * se;
  endfunction

  // Add half, floor shift by the fraction width, clamp to 16 bits
  function automatic sample_t round_sat(input acc_t acc);
    acc_t                  r;
    logic signed [Q_W-1:0] q;
    logic signed [Q_W-1:0] q_max;
    logic signed [Q_W-1:0] q_min;
    q_max = Q_W'(32'sd32767);
    q_min = Q_W'(-32'sd32768);
    r = acc + ROUND_BIAS;
    q = r[ACC_W-1:FRAC_W];
    if (q > q_max) begin
      return sample_t'(q_max[SAMPLE_W-1:0]);
    end else if (q < q_min) begin
      return sample_t'(q_min[SAMPLE_W-1:0]);
    end
    return sample_t'(q[SAMPLE_W-1:0]);
  endfunction

endpackage

@@ src/mbl_in_if.sv @@
interface mbl_in_if;
  logic                              valid;
  logic                              ready;
  logic [mbl_pkg::CHAN_W-1:0]        channel;
  logic signed [mbl_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

@@ src/mbl_out_if.sv @@
interface mbl_out_if;
  logic                                valid;
  logic                                ready;
  logic [mbl_pkg::CHAN_W-1:0]          channel_out;
  logic signed [mbl_pkg::SAMPLE_W-1:0] filtered;

  modport source (output valid, output channel_out, output filtered, input ready);
  modport sink   (input valid, input channel_out, input filtered, output ready);
endinterface

@@ src/mbl_ram.sv @@
module mbl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/multichannel_biquad_lowpass.sv @@
// Channel  Dir  Words                        Handshake
// in_i     in   channel, sample              valid/ready
// out_o    out  channel_out, filtered        valid/ready
// apb      in   enable, num0..2, den1..2     psel/penable/pwrite, pready tied high
//
// Path from the accepting edge to the output register: products, sum, round/saturate
// with write-back; the history read is issued on the accepting edge.
// One word per cycle while successive words name different channels and the output
// does not stall; a word whose channel is still in one of the three stages behind
// the history memory waits for that word's write-back (read-modify-write loop).
// Reset clears the registers, the primed flags and the stage valids; no sweep.
// A full output register holds its stage while the earlier stages keep filling.
module multichannel_biquad_lowpass #(
  parameter int unsigned CHANNELS = mbl_pkg::CHANNELS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mbl_in_if.sink                       in_i,
  mbl_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mbl_pkg::ADDR_W-1:0]   paddr,
  input  logic [mbl_pkg::PDATA_W-1:0]  pwdata,
  output logic [mbl_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef struct packed {
    logic [mbl_pkg::CHAN_W-1:0] ch;
    mbl_pkg::sample_t           x;
    logic                       in_range;
    logic                       primed;
  } s1_t;

  typedef struct packed {
    logic [mbl_pkg::CHAN_W-1:0] ch;
    mbl_pkg::sample_t           x;
    logic                       in_range;
    logic                       primed;
    mbl_pkg::sample_t           x1h;
    mbl_pkg::sample_t           y1h;
    mbl_pkg::prod_t             p0;
    mbl_pkg::prod_t             p1;
    mbl_pkg::prod_t             p2;
    mbl_pkg::prod_t             p3;
    mbl_pkg::prod_t             p4;
  } s2_t;

  typedef struct packed {
    logic [mbl_pkg::CHAN_W-1:0] ch;
    mbl_pkg::sample_t           x;
    logic                       in_range;
    logic                       primed;
    mbl_pkg::sample_t           x1h;
    mbl_pkg::sample_t           y1h;
    mbl_pkg::acc_t              acc;
  } s3_t;

  typedef struct packed {
    logic [mbl_pkg::CHAN_W-1:0] ch;
    mbl_pkg::sample_t           y;
  } out_t;

  // configuration
  logic             enable_q;
  mbl_pkg::coef_t   num0_q, num1_q, num2_q, den1_q, den2_q;
  logic             cfg_wr;
  logic             cfg_hit;
  mbl_pkg::reg_idx_e cfg_idx;

  // primed flags
  logic [CHANNELS-1:0] primed_q;

  // pipeline
  logic    s1_v_q, s2_v_q, s3_v_q, out_v_q;
  s1_t     s1_q, s1_d;
  s2_t     s2_q, s2_d;
  s3_t     s3_q, s3_d;
  out_t    out_q, out_d;
  logic    move1, move2, move3, ld1, ld2, ld3;
  logic    hazard, in_acc, in_range;
  logic [AW-1:0] in_addr;

  // memory
  logic [mbl_pkg::HIST_W-1:0] rdata;
  mbl_pkg::hist_t             hist_rd, hist_use, hist_wr;
  logic                       mem_we;

  // Register port
  assign pready  = 1'b1;
  assign cfg_idx = mbl_pkg::reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_comb begin
    cfg_hit = 1'b1;
    prdata  = '0;
    unique case (cfg_idx)
      mbl_pkg::REG_ENABLE: prdata = {{(mbl_pkg::PDATA_W-1){1'b0}}, enable_q};
      mbl_pkg::REG_NUM0: prdata = {{(mbl_pkg::PDATA_W-mbl_pkg::COEF_W){num0_q[17]}}, num0_q};
      mbl_pkg::REG_NUM1: prdata = {{(mbl_pkg::PDATA_W-mbl_pkg::COEF_W){num1_q[17]}}, num1_q};
      mbl_pkg::REG_NUM2: prdata = {{(mbl_pkg::PDATA_W-mbl_pkg::COEF_W){num2_q[17]}}, num2_q};
      mbl_pkg::REG_DEN1: prdata = {{(mbl_pkg::PDATA_W-mbl_pkg::COEF_W){den1_q[17]}}, den1_q};
      mbl_pkg::REG_DEN2: prdata = {{(mbl_pkg::PDATA_W-mbl_pkg::COEF_W){den2_q[17]}}, den2_q};
      default:           cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      num0_q   <= mbl_pkg::coef_t'(18'sd65536);
      num1_q   <= '0;
      num2_q   <= '0;
      den1_q   <= '0;
      den2_q   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        mbl_pkg::REG_ENABLE: enable_q <= pwdata[0];
        mbl_pkg::REG_NUM0:   num0_q   <= pwdata[mbl_pkg::COEF_W-1:0];
        mbl_pkg::REG_NUM1:   num1_q   <= pwdata[mbl_pkg::COEF_W-1:0];
        mbl_pkg::REG_NUM2:   num2_q   <= pwdata[mbl_pkg::COEF_W-1:0];
        mbl_pkg::REG_DEN1:   den1_q   <= pwdata[mbl_pkg::COEF_W-1:0];
        mbl_pkg::REG_DEN2:   den2_q   <= pwdata[mbl_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage handshakes; each stage moves when the one after it can take the word
  assign move3 = s3_v_q & (~out_v_q | out_o.ready);
  assign ld3   = ~s3_v_q | move3;
  assign move2 = s2_v_q & ld3;
  assign ld2   = ~s2_v_q | move2;
  assign move1 = s1_v_q & ld2;
  assign ld1   = ~s1_v_q | move1;

  // Interlock: a channel already in flight has not written its history back yet
  assign hazard = (s1_v_q & (s1_q.ch == in_i.channel)) |
                  (s2_v_q & (s2_q.ch == in_i.channel)) |
                  (s3_v_q & (s3_q.ch == in_i.channel));

  assign in_i.ready = ld1 & ~hazard;
  assign in_acc     = in_i.valid & in_i.ready;
  assign in_range   = 32'(in_i.channel) < CHANNELS;
  assign in_addr    = AW'(in_i.channel);

  // Primed flags: set on first word of a channel, cleared by any write to a defined register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= '0;
    end else if (cfg_wr & cfg_hit) begin
      primed_q <= '0;
    end else if (in_acc & in_range) begin
      primed_q[in_addr] <= 1'b1;
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_q <= 1'b1;
      end else if (move1) begin
        s1_v_q <= 1'b0;
      end
      if (move1) begin
        s2_v_q <= 1'b1;
      end else if (move2) begin
        s2_v_q <= 1'b0;
      end
      if (move2) begin
        s3_v_q <= 1'b1;
      end else if (move3) begin
        s3_v_q <= 1'b0;
      end
      if (move3) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Stage 1 capture
  always_comb begin
    s1_d.ch       = in_i.channel;
    s1_d.x        = in_i.sample;
    s1_d.in_range = in_range;
    s1_d.primed   = in_range ? primed_q[in_addr] : 1'b1;
  end

  // Stage 1: history from memory, or the sample itself on a channel's first word
  assign hist_rd = mbl_pkg::hist_t'(rdata);

  always_comb begin
    if (s1_q.primed) begin
      hist_use = hist_rd;
    end else begin
      hist_use = '{x1: s1_q.x, x2: s1_q.x, y1: s1_q.x, y2: s1_q.x};
    end
    s2_d.ch       = s1_q.ch;
    s2_d.x        = s1_q.x;
    s2_d.in_range = s1_q.in_range;
    s2_d.primed   = s1_q.primed;
    s2_d.x1h      = hist_use.x1;
    s2_d.y1h      = hist_use.y1;
    s2_d.p0       = mbl_pkg::mul(num0_q, s1_q.x);
    s2_d.p1       = mbl_pkg::mul(num1_q, hist_use.x1);
    s2_d.p2       = mbl_pkg::mul(num2_q, hist_use.x2);
    s2_d.p3       = mbl_pkg::mul(den1_q, hist_use.y1);
    s2_d.p4       = mbl_pkg::mul(den2_q, hist_use.y2);
  end

  // Stage 2: sum of products
  always_comb begin
    s3_d.ch       = s2_q.ch;
    s3_d.x        = s2_q.x;
    s3_d.in_range = s2_q.in_range;
    s3_d.primed   = s2_q.primed;
    s3_d.x1h      = s2_q.x1h;
    s3_d.y1h      = s2_q.y1h;
    s3_d.acc      = mbl_pkg::acc_t'(s2_q.p0) + mbl_pkg::acc_t'(s2_q.p1)
                  + mbl_pkg::acc_t'(s2_q.p2) - mbl_pkg::acc_t'(s2_q.p3)
                  - mbl_pkg::acc_t'(s2_q.p4);
  end

  // Stage 3: round, saturate, bypass, write history back
  always_comb begin
    out_d.ch = s3_q.ch;
    if (enable_q & s3_q.in_range) begin
      out_d.y = mbl_pkg::round_sat(s3_q.acc);
    end else begin
      out_d.y = s3_q.x;
    end
    // a bypassed first word stores the sample everywhere, which this also gives
    hist_wr = '{x1: s3_q.x, x2: s3_q.x1h, y1: out_d.y, y2: s3_q.y1h};
    mem_we  = move3 & s3_q.in_range & (enable_q | ~s3_q.primed);
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (move1) begin
      s2_q <= s2_d;
    end
    if (move2) begin
      s3_q <= s3_d;
    end
    if (move3) begin
      out_q <= out_d;
    end
  end

  // Per-channel history memory
  mbl_ram #(
    .WIDTH (mbl_pkg::HIST_W),
    .DEPTH (CHANNELS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(s3_q.ch)),
    .wdata_i (hist_wr),
    .re_i    (in_acc),
    .raddr_i (in_addr),
    .rdata_o (rdata)
  );

  assign out_o.valid       = out_v_q;
  assign out_o.channel_out = out_q.ch;
  assign out_o.filtered    = out_q.y;

endmodule

@@ src/mbl_checker.sv @@
module mbl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mbl_pkg::CHAN_W-1:0]    out_channel,
  input logic [mbl_pkg::SAMPLE_W-1:0]  out_filtered,
  input logic                          psel,
  input logic                          pwrite,
  input logic [mbl_pkg::ADDR_W-1:0]    paddr,
  input logic [mbl_pkg::PDATA_W-1:0]   prdata
);

  logic       in_acc, out_acc;
  logic [2:0] cnt_q;

  assign in_acc  = in_valid & in_ready;
  assign out_acc = out_valid & out_ready;

  // words taken in and not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc & ~out_acc) begin
      cnt_q <= cnt_q + 3'd1;
    end else if (out_acc & ~in_acc) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_channel) && $stable(out_filtered))
    else $error("output word changed while stalled");

  // no word delivered that was never taken in
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> cnt_q != 3'd0)
    else $error("output word without input word");

  // at most four words in flight: three stages and the output register
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("too many words in flight");

  // output register empty straight after reset
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid)
    else $error("output valid after reset");

  // enable reads back as a single bit
  a_enable_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && !pwrite && (paddr[4:2] == mbl_pkg::REG_ENABLE) |-> prdata[31:1] == 31'd0)
    else $error("enable read returned extra bits");

endmodule

bind multichannel_biquad_lowpass mbl_checker u_mbl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_i.valid),
  .in_ready     (in_i.ready),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .out_channel  (out_o.channel_out),
  .out_filtered (out_o.filtered),
  .psel         (psel),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .prdata       (prdata)
);
